@@ rtl/lpht_pkg.sv @@
// Shared types and constants of the linear probing hash table.
`default_nettype none

package lpht_pkg;

  localparam int KEY_W     = 64;
  localparam int WORD_W    = 64;
  localparam int SLOT_W    = 10;
  localparam int CNT_W     = 11;
  localparam int LIMIT_W   = 11;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } opcode_e;

  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TOMB_KEY    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_LIMIT = 4'd1;

  localparam logic [KEY_W-1:0]   TOMB_KEY_RESET    = 64'd8;
  localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RESET = 11'd1024;

  // Multipliers of the three mixing rounds.
  localparam logic [31:0] MIX_C0 = 32'd2654435761;
  localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

endpackage

`default_nettype wire

@@ rtl/linear_probe_hash_table.sv @@
// Top level of the linear probing hash table with tombstones.
`default_nettype none

// Open-addressing table of CAPACITY slots keyed by 64-bit addresses. Each word on the input
// channel is an insert, lookup or delete; each gives exactly one result word carrying a status,
// the slot, the two data words and the live and tombstone counts after the operation. Keys live
// in one synchronous memory and the two data words in a second one, both with a registered read.
// After reset the key memory is swept to empty, one slot a cycle, so the input channel stays
// not ready until the sweep ends; configuration writes are taken at any time. One word is handled
// at a time: three hash rounds on the split 32-bit multipliers, then, when CAPACITY is not a
// power of two, the modulo reduction to a home slot, then the probe, which walks the key
// memory's read port one slot at a time, then one step to resolve and write back and one to
// load the output register. A finished result waits in the output register while the next
// word is already being accepted.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [KEY_W-1:0]      key_i,
  input  wire logic [WORD_W-1:0]     class_word_i,
  input  wire logic [WORD_W-1:0]     data_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [SLOT_W-1:0]          slot_o,
  output logic [WORD_W-1:0]          class_out_o,
  output logic [WORD_W-1:0]          data_out_o,
  output logic [CNT_W-1:0]           live_count_o,
  output logic [CNT_W-1:0]           dead_count_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [KEY_W-1:0]      cfg_data_i
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_PROBE = 6'b001000,
    S_FIN   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  // Control state.
  state_e               state_q, state_d;
  logic [IW-1:0]        clr_q, clr_d;
  logic [KEY_W-1:0]     tomb_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [CW-1:0]        live_q, live_d;
  logic [CW-1:0]        dead_q, dead_d;
  logic [CW-1:0]        n_q, n_d;
  logic [CW-1:0]        i_q, i_d;
  logic                 hit_q, hit_d;
  logic                 empty_q, empty_d;
  logic                 have_tomb_q, have_tomb_d;
  logic                 out_valid_q, out_valid_d;

  // Payload state.
  logic [1:0]           op_q;
  logic [KEY_W-1:0]     key_q;
  logic [WORD_W-1:0]    cw_q, dw_q;
  logic [IW-1:0]        pidx_q, pidx_d;
  logic [IW-1:0]        tidx_q, tidx_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [IW-1:0]        res_slot_q, res_slot_d;
  logic                 res_rd_q, res_rd_d;
  logic [WORD_W-1:0]    res_cw_q, res_cw_d, res_dw_q, res_dw_d;
  logic [STATUS_W-1:0]  o_status_q;
  logic [SLOT_W-1:0]    o_slot_q;
  logic [WORD_W-1:0]    o_cw_q, o_dw_q;
  logic [CNT_W-1:0]     o_live_q, o_dead_q;

  // Memories and their ports.
  logic [KEY_W-1:0]     key_mem [CAPACITY];
  logic [2*WORD_W-1:0]  word_mem [CAPACITY];
  logic                 km_we, km_re;
  logic [IW-1:0]        km_waddr, km_raddr;
  logic [KEY_W-1:0]     km_wdata, km_rdata_q;
  logic                 wm_we, wm_re;
  logic [IW-1:0]        wm_addr;
  logic [2*WORD_W-1:0]  wm_wdata, wm_rdata_q;

  // Hash unit.
  logic                 hash_start;
  logic                 hash_done;
  logic [IW-1:0]        hash_home;

  // Probe and resolve helpers.
  logic                 accept, bad_req, load_out;
  logic                 s_empty, s_tomb, s_hit;
  logic                 full, tomb_ok, is_ins;
  logic [IW-1:0]        pidx_next;
  logic [LW-1:0]        lim_ext;
  logic [IW+SLOT_W-1:0] slot_ext;
  logic [CW+CNT_W-1:0]  live_ext, dead_ext;

  lpht_hash #(
    .CAPACITY(CAPACITY)
  ) u_lpht_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_i),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign bad_req     = (opcode_i != OP_INSERT && opcode_i != OP_LOOKUP &&
                        opcode_i != OP_DELETE) || (key_i == '0) || (key_i == tomb_q);
  assign hash_start  = accept && !bad_req;
  assign load_out    = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // The stored key under examination is the one read for pidx_q in the previous cycle.
  assign s_empty   = (km_rdata_q == '0);
  assign s_tomb    = (km_rdata_q == tomb_q);
  assign s_hit     = !s_empty && !s_tomb && (km_rdata_q == key_q);
  assign pidx_next = (pidx_q == LAST_SLOT) ? '0 : pidx_q + 1'b1;
  assign lim_ext   = LW'(limit_q);
  assign full      = (n_q == CAP_CNT);
  // With no empty slot met, a passed tombstone may only be reused once every slot was seen.
  assign tomb_ok   = have_tomb_q && (empty_q || full);
  assign is_ins    = (op_q == OP_INSERT);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    live_d       = live_q;
    dead_d       = dead_q;
    n_d          = n_q;
    i_d          = i_q;
    hit_d        = hit_q;
    empty_d      = empty_q;
    have_tomb_d  = have_tomb_q;
    pidx_d       = pidx_q;
    tidx_d       = tidx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_rd_d     = res_rd_q;
    res_cw_d     = res_cw_q;
    res_dw_d     = res_dw_q;
    km_we        = 1'b0;
    km_waddr     = pidx_q;
    km_wdata     = key_q;
    km_re        = 1'b0;
    km_raddr     = pidx_next;
    wm_we        = 1'b0;
    wm_re        = 1'b0;
    wm_addr      = pidx_q;
    wm_wdata     = {cw_q, dw_q};

    case (state_q)
      S_CLEAR: begin
        km_we    = 1'b1;
        km_waddr = clr_q;
        km_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (bad_req) begin
            res_status_d = ST_INVALID;
            res_slot_d   = '0;
            res_rd_d     = 1'b0;
            res_cw_d     = '0;
            res_dw_d     = '0;
            state_d      = S_EMIT;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          n_d         = (lim_ext < LW'(CAPACITY)) ? CW'(lim_ext) : CAP_CNT;
          i_d         = '0;
          hit_d       = 1'b0;
          empty_d     = 1'b0;
          have_tomb_d = 1'b0;
          pidx_d      = hash_home;
          km_re       = 1'b1;
          km_raddr    = hash_home;
          state_d     = (limit_q == '0) ? S_FIN : S_PROBE;
        end
      end
      S_PROBE: begin
        // The next slot is read ahead every cycle; no write happens while probing.
        km_re = 1'b1;
        if (s_empty) begin
          empty_d = 1'b1;
          state_d = S_FIN;
        end else if (s_hit) begin
          hit_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          if (s_tomb && !have_tomb_q) begin
            have_tomb_d = 1'b1;
            tidx_d      = pidx_q;
          end
          if (i_q + 1'b1 == n_q) begin
            state_d = S_FIN;
          end else begin
            i_d    = i_q + 1'b1;
            pidx_d = pidx_next;
          end
        end
      end
      S_FIN: begin
        res_rd_d   = 1'b0;
        res_cw_d   = '0;
        res_dw_d   = '0;
        res_slot_d = '0;
        state_d    = S_EMIT;
        if (is_ins) begin
          if (hit_q) begin
            wm_we        = 1'b1;
            res_status_d = ST_FOUND;
            res_slot_d   = pidx_q;
            res_cw_d     = cw_q;
            res_dw_d     = dw_q;
          end else if (tomb_ok || empty_q) begin
            km_we        = 1'b1;
            wm_we        = 1'b1;
            km_waddr     = tomb_ok ? tidx_q : pidx_q;
            wm_addr      = tomb_ok ? tidx_q : pidx_q;
            res_status_d = ST_NEW;
            res_slot_d   = tomb_ok ? tidx_q : pidx_q;
            res_cw_d     = cw_q;
            res_dw_d     = dw_q;
            if (live_q != CAP_CNT) begin
              live_d = live_q + 1'b1;
            end
            if (tomb_ok && dead_q != '0) begin
              dead_d = dead_q - 1'b1;
            end
          end else begin
            res_status_d = ST_FULL;
          end
        end else if (!hit_q) begin
          res_status_d = (empty_q || full) ? ST_MISS : ST_FULL;
        end else begin
          // Hit on lookup or delete: the words come from the word memory next cycle.
          wm_re        = 1'b1;
          res_rd_d     = 1'b1;
          res_status_d = ST_FOUND;
          res_slot_d   = pidx_q;
          if (op_q == OP_DELETE) begin
            km_we    = 1'b1;
            km_wdata = tomb_q;
            if (live_q != '0) begin
              live_d = live_q - 1'b1;
            end
            if (dead_q != CAP_CNT) begin
              dead_d = dead_q + 1'b1;
            end
          end
        end
      end
      S_EMIT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, res_slot_q};
  assign live_ext = {{CNT_W{1'b0}}, live_q};
  assign dead_ext = {{CNT_W{1'b0}}, dead_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      tomb_q      <= TOMB_KEY_RESET;
      limit_q     <= PROBE_LIMIT_RESET;
      live_q      <= '0;
      dead_q      <= '0;
      n_q         <= '0;
      i_q         <= '0;
      hit_q       <= 1'b0;
      empty_q     <= 1'b0;
      have_tomb_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      live_q      <= live_d;
      dead_q      <= dead_d;
      n_q         <= n_d;
      i_q         <= i_d;
      hit_q       <= hit_d;
      empty_q     <= empty_d;
      have_tomb_q <= have_tomb_d;
      out_valid_q <= out_valid_d;
      // A zero tombstone key would alias the empty marker, so such a write is dropped.
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_TOMB_KEY && cfg_data_i != '0) begin
          tomb_q <= cfg_data_i;
        end else if (cfg_index_i == REG_PROBE_LIMIT) begin
          limit_q <= cfg_data_i[LIMIT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      cw_q  <= class_word_i;
      dw_q  <= data_word_i;
    end
    pidx_q       <= pidx_d;
    tidx_q       <= tidx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_rd_q     <= res_rd_d;
    res_cw_q     <= res_cw_d;
    res_dw_q     <= res_dw_d;
    if (load_out) begin
      o_status_q <= res_status_q;
      o_slot_q   <= slot_ext[SLOT_W-1:0];
      o_cw_q     <= res_rd_q ? wm_rdata_q[2*WORD_W-1:WORD_W] : res_cw_q;
      o_dw_q     <= res_rd_q ? wm_rdata_q[WORD_W-1:0] : res_dw_q;
      o_live_q   <= live_ext[CNT_W-1:0];
      o_dead_q   <= dead_ext[CNT_W-1:0];
    end
  end

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (km_we) begin
      key_mem[km_waddr] <= km_wdata;
    end
    if (km_re) begin
      km_rdata_q <= key_mem[km_raddr];
    end
  end

  // Word memory: class word in the upper half, data word in the lower half.
  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      word_mem[wm_addr] <= wm_wdata;
    end
    if (wm_re) begin
      wm_rdata_q <= word_mem[wm_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = o_status_q;
  assign slot_o       = o_slot_q;
  assign class_out_o  = o_cw_q;
  assign data_out_o   = o_dw_q;
  assign live_count_o = o_live_q;
  assign dead_count_o = o_dead_q;

endmodule

`default_nettype wire

@@ rtl/lpht_hash.sv @@
// Iterative key hash: three multiply and xor-shift rounds, then reduction to a home slot.
`default_nettype none

module lpht_hash import lpht_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [KEY_W-1:0]             key_i,
  output logic                              done_o,
  output logic [$clog2(CAPACITY)-1:0]       home_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [IW:0] CAP_R = (IW + 1)'(CAPACITY);

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_MUL  = 5'b00010,
    H_MIX  = 5'b00100,
    H_MOD  = 5'b01000,
    H_DONE = 5'b10000
  } hstate_e;

  hstate_e           state_q, state_d;
  logic [1:0]        round_q, round_d;
  logic [2:0]        dig_q, dig_d;
  logic [63:0]       h_q, h_d;
  logic [63:0]       plo_q, plo_d;
  logic [31:0]       phi_q, phi_d;
  logic [IW-1:0]     r_q, r_d;
  logic [IW-1:0]     home_q, home_d;

  logic [31:0]       mul_c;
  logic [63:0]       mul_lo, mul_hi, prod, mixed;
  logic [IW:0]       r_t;

  always_comb begin
    case (round_q)
      2'd0:    mul_c = MIX_C0;
      2'd1:    mul_c = MIX_C1;
      default: mul_c = MIX_C2;
    endcase
  end

  // The 64-bit product modulo 2^64 is split into two 32 by 32 partial products.
  assign mul_lo = {32'b0, h_q[31:0]} * {32'b0, mul_c};
  assign mul_hi = {32'b0, h_q[63:32]} * {32'b0, mul_c};
  assign prod   = plo_q + {phi_q, 32'b0};
  assign mixed  = (round_q == 2'd1) ? (prod ^ (prod >> 13)) : (prod ^ (prod >> 16));

  // Eight bits of the dividend a cycle, one compare and subtract per bit.
  always_comb begin
    r_t = {1'b0, r_q};
    for (int j = 0; j < 8; j++) begin
      r_t = {r_t[IW-1:0], h_q[63-j]};
      if (r_t >= CAP_R) begin
        r_t = r_t - CAP_R;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    dig_d   = dig_q;
    h_d     = h_q;
    plo_d   = plo_q;
    phi_d   = phi_q;
    r_d     = r_q;
    home_d  = home_q;
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          h_d     = {3'b0, key_i[63:3]};
          round_d = 2'd0;
          state_d = H_MUL;
        end
      end
      H_MUL: begin
        plo_d   = mul_lo;
        phi_d   = mul_hi[31:0];
        state_d = H_MIX;
      end
      H_MIX: begin
        h_d = mixed;
        if (round_q == 2'd2) begin
          if (POW2) begin
            home_d  = mixed[IW-1:0];
            state_d = H_DONE;
          end else begin
            r_d     = '0;
            dig_d   = '0;
            state_d = H_MOD;
          end
        end else begin
          round_d = round_q + 2'd1;
          state_d = H_MUL;
        end
      end
      H_MOD: begin
        r_d   = r_t[IW-1:0];
        h_d   = h_q << 8;
        dig_d = dig_q + 3'd1;
        if (dig_q == 3'd7) begin
          home_d  = r_t[IW-1:0];
          state_d = H_DONE;
        end
      end
      H_DONE: begin
        state_d = H_IDLE;
      end
      default: begin
        state_d = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      round_q <= '0;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      dig_q   <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    r_q    <= r_d;
    home_q <= home_d;
  end

  assign done_o = (state_q == H_DONE);
  assign home_o = home_q;

endmodule

`default_nettype wire

@@ rtl/lpht_checker.sv @@
// Port-level checks of the linear probing hash table and their binding.
`default_nettype none

module lpht_checker import lpht_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_o,
  input  wire logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire logic [STATUS_W-1:0]   status_o,
  input  wire logic [SLOT_W-1:0]     slot_o,
  input  wire logic [WORD_W-1:0]     class_out_o,
  input  wire logic [WORD_W-1:0]     data_out_o
);

  // A result word held back by the consumer stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(slot_o) &&
      $stable(class_out_o) && $stable(data_out_o))
    else $error("result word changed while stalled");

  // Misses, refusals and invalid requests carry no slot and no words.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MISS || status_o == ST_FULL || status_o == ST_INVALID)
      |-> slot_o == '0 && class_out_o == '0 && data_out_o == '0)
    else $error("non-hit result carries slot or words");

  // An accepted request occupies the engine for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("engine ready straight after accepting a request");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .slot_o      (slot_o),
  .class_out_o (class_out_o),
  .data_out_o  (data_out_o)
);

`default_nettype wire
